/* sv/multi_channel_actuator_flasher_macros.svh */
// Assertion macros for the multi-channel actuator flasher.
`ifndef MULTI_CHANNEL_ACTUATOR_FLASHER_MACROS_SVH
`define MULTI_CHANNEL_ACTUATOR_FLASHER_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define MCAF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcaf: same-cycle check failed");

// The antecedent implies the consequent in the following cycle.
`define MCAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcaf: next-cycle check failed");

`endif

/* sv/mcaf_pkg.sv */
// Types and constants shared by the multi-channel actuator flasher.
`default_nettype none
package mcaf_pkg;

  // Operation codes of a request.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Request kinds.
  localparam logic [2:0] K_ACTIVATE    = 3'd0;
  localparam logic [2:0] K_DEACTIVATE  = 3'd1;
  localparam logic [2:0] K_FAST_TIMED  = 3'd2;
  localparam logic [2:0] K_FAST_STEADY = 3'd3;
  localparam logic [2:0] K_SLOW_TIMED  = 3'd4;
  localparam logic [2:0] K_SLOW_STEADY = 3'd5;

  // Channel status codes.
  localparam logic [1:0] ST_UNTREATED = 2'd0;
  localparam logic [1:0] ST_UNDER     = 2'd1;
  localparam logic [1:0] ST_FINISHED  = 2'd2;

  // Register indexes and reset values.
  localparam logic REG_FAST_PERIOD = 1'b0;
  localparam logic REG_SLOW_PERIOD = 1'b1;
  localparam logic [7:0] FAST_PERIOD_RST = 8'd1;
  localparam logic [7:0] SLOW_PERIOD_RST = 8'd5;

  typedef struct packed {
    logic       operation;
    logic [2:0] channel;
    logic [2:0] request_kind;
    logic [7:0] duration;
  } req_t;

  typedef struct packed {
    logic [7:0] levels;
    logic [7:0] busy_res;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DIV   = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

/* sv/multi_channel_actuator_flasher.sv */
// Store request: the table is written on accept, then the done state posts the result; one request at a time.
// Tick request: walks every channel in the scan state; a timed flash channel with a nonzero
// count also passes through the divide and apply states (a shared 8-step restoring divider
// forms count mod period), then the done state posts the result.
// Synchronous active-high reset sets all channels finished, kinds and counts
// to zero, all levels off and the periods to 1 and 5.
`default_nettype none
`include "multi_channel_actuator_flasher_macros.svh"
module multi_channel_actuator_flasher #(
  parameter int CHANNELS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_ready,
  input  wire mcaf_pkg::req_t req,
  output      logic           res_valid,
  input  wire logic           res_ready,
  output      mcaf_pkg::res_t res,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output      logic [31:0]    prdata,
  output      logic           pready
);

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CHANNELS - 1);

  mcaf_pkg::state_t state;

  // Channel tables and drive levels.
  logic [2:0]          kind_tbl   [CHANNELS];
  logic [1:0]          status_tbl [CHANNELS];
  logic [7:0]          count_tbl  [CHANNELS];
  logic [CHANNELS-1:0] lvl;
  logic [CHANNELS-1:0] busy;

  logic [7:0]      fast_period;
  logic [7:0]      slow_period;
  logic [IDXW-1:0] idx;

  // Shared divider registers.
  logic [7:0] dvd;
  logic [7:0] dvs;
  logic [7:0] rem;
  logic [2:0] step;
  logic [8:0] rem_sh;
  logic       rem_ge;
  logic [7:0] rem_next;

  logic [2:0]      cur_kind;
  logic [1:0]      cur_st;
  logic [7:0]      cur_cnt;
  logic [7:0]      cnt_dec;
  logic [7:0]      fp_eff;
  logic [7:0]      sp_eff;
  logic [IDXW-1:0] store_idx;
  logic            store_ok;
  logic            cfg_wr;
  logic [31:0]     lvl_w;
  logic [31:0]     busy_w;

  assign req_ready = (state == mcaf_pkg::S_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    if (paddr[2] == mcaf_pkg::REG_SLOW_PERIOD) begin
      prdata = {24'd0, slow_period};
    end else begin
      prdata = {24'd0, fast_period};
    end
  end

  // Current channel and effective periods; a zero period acts as one.
  assign cur_kind  = kind_tbl[idx];
  assign cur_st    = status_tbl[idx];
  assign cur_cnt   = count_tbl[idx];
  assign cnt_dec   = cur_cnt - 8'd1;
  assign fp_eff    = (fast_period == 8'd0) ? 8'd1 : fast_period;
  assign sp_eff    = (slow_period == 8'd0) ? 8'd1 : slow_period;
  assign store_idx = IDXW'(req.channel);
  assign store_ok  = (32'(req.channel) < CHANNELS);

  // One restoring division step per cycle.
  assign rem_sh   = {rem, dvd[7]};
  assign rem_ge   = (rem_sh >= {1'b0, dvs});
  assign rem_next = rem_ge ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];

  // Busy bitmap from the status of every channel.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      busy[c] = (status_tbl[c] != mcaf_pkg::ST_FINISHED);
    end
  end

  assign lvl_w  = 32'(lvl);
  assign busy_w = 32'(busy);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period <= mcaf_pkg::FAST_PERIOD_RST;
      slow_period <= mcaf_pkg::SLOW_PERIOD_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == mcaf_pkg::REG_SLOW_PERIOD) begin
        slow_period <= pwdata[7:0];
      end else begin
        fast_period <= pwdata[7:0];
      end
    end
  end

  // Sequencer, channel tables and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcaf_pkg::S_IDLE;
      idx       <= '0;
      lvl       <= '0;
      res_valid <= 1'b0;
      step      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        kind_tbl[c]   <= '0;
        status_tbl[c] <= mcaf_pkg::ST_FINISHED;
        count_tbl[c]  <= '0;
      end
    end else begin
      // The done state posts its own result, so it handles valid itself.
      if (res_valid && res_ready && state != mcaf_pkg::S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        mcaf_pkg::S_IDLE: begin
          if (req_valid) begin
            idx <= '0;
            if (req.operation == mcaf_pkg::OP_TICK) begin
              state <= mcaf_pkg::S_SCAN;
            end else begin
              if (store_ok) begin
                kind_tbl[store_idx]   <= req.request_kind;
                count_tbl[store_idx]  <= req.duration;
                status_tbl[store_idx] <= mcaf_pkg::ST_UNTREATED;
              end
              state <= mcaf_pkg::S_DONE;
            end
          end
        end

        mcaf_pkg::S_SCAN: begin
          // Timed flashes with a count left go through the divider.
          if (cur_st != mcaf_pkg::ST_FINISHED &&
              (cur_kind == mcaf_pkg::K_FAST_TIMED || cur_kind == mcaf_pkg::K_SLOW_TIMED) &&
              cur_cnt != 8'd0) begin
            rem   <= '0;
            step  <= '0;
            state <= mcaf_pkg::S_DIV;
            if (cur_kind == mcaf_pkg::K_FAST_TIMED) begin
              dvd <= cur_cnt;
              dvs <= fp_eff;
            end else begin
              dvd            <= cnt_dec;
              dvs            <= sp_eff;
              count_tbl[idx] <= cnt_dec;
            end
          end else begin
            if (cur_st != mcaf_pkg::ST_FINISHED) begin
              case (cur_kind)
                mcaf_pkg::K_FAST_TIMED, mcaf_pkg::K_SLOW_TIMED: begin
                  // Count spent: switch off and retire.
                  lvl[idx]        <= 1'b0;
                  status_tbl[idx] <= mcaf_pkg::ST_FINISHED;
                end
                mcaf_pkg::K_FAST_STEADY, mcaf_pkg::K_SLOW_STEADY: begin
                  if (cur_cnt == 8'd0) begin
                    lvl[idx] <= ~lvl[idx];
                    count_tbl[idx] <= (cur_kind == mcaf_pkg::K_FAST_STEADY) ?
                                      fp_eff - 8'd1 : sp_eff - 8'd1;
                  end else begin
                    count_tbl[idx] <= cnt_dec;
                  end
                end
                mcaf_pkg::K_ACTIVATE: begin
                  if (cur_st == mcaf_pkg::ST_UNTREATED) begin
                    lvl[idx] <= 1'b1;
                    status_tbl[idx] <= (cur_cnt == 8'd0) ? mcaf_pkg::ST_FINISHED :
                                                           mcaf_pkg::ST_UNDER;
                  end else begin
                    count_tbl[idx] <= cnt_dec;
                    if (cnt_dec == 8'd0) begin
                      lvl[idx]        <= 1'b0;
                      status_tbl[idx] <= mcaf_pkg::ST_FINISHED;
                    end
                  end
                end
                mcaf_pkg::K_DEACTIVATE: begin
                  lvl[idx]        <= 1'b0;
                  status_tbl[idx] <= mcaf_pkg::ST_FINISHED;
                end
                default: begin
                  // Unknown kinds retire without touching the output.
                  status_tbl[idx] <= mcaf_pkg::ST_FINISHED;
                end
              endcase
            end
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= mcaf_pkg::S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        mcaf_pkg::S_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[6:0], 1'b0};
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= mcaf_pkg::S_APPLY;
          end
        end

        mcaf_pkg::S_APPLY: begin
          // Toggle on a period boundary; the fast count drops afterwards.
          if (rem == 8'd0) begin
            lvl[idx] <= ~lvl[idx];
          end
          if (cur_kind == mcaf_pkg::K_FAST_TIMED) begin
            count_tbl[idx] <= cnt_dec;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= mcaf_pkg::S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= mcaf_pkg::S_SCAN;
          end
        end

        mcaf_pkg::S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= mcaf_pkg::S_IDLE;
          end
        end

        default: begin
          state <= mcaf_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded as the result is posted.
  always_ff @(posedge clk) begin
    if (state == mcaf_pkg::S_DONE && (!res_valid || res_ready)) begin
      res.levels   <= lvl_w[7:0];
      res.busy_res <= busy_w[7:0];
    end
  end

  // The divider remainder stays below the divisor.
  `MCAF_ASSERT_SAME(a_rem_below_divisor, state == mcaf_pkg::S_DIV, rem < dvs)
  // Eight division steps lead straight to the apply step.
  `MCAF_ASSERT_NEXT(a_div_to_apply, state == mcaf_pkg::S_DIV && step == 3'd7,
                    state == mcaf_pkg::S_APPLY)
  // A stored request leaves its channel untreated.
  `MCAF_ASSERT_NEXT(a_store_untreated,
                    req_valid && req_ready && req.operation == mcaf_pkg::OP_STORE && store_ok,
                    status_tbl[$past(store_idx)] == mcaf_pkg::ST_UNTREATED)

endmodule
`default_nettype wire

/* tb/multi_channel_actuator_flasher_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the multi-channel actuator flasher, checked against a predictor.
module multi_channel_actuator_flasher_test;

  localparam int NUM_CH = 8;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;

  // One row of the directed script; typed rows carry a hand-written result.
  typedef struct packed {
    mcaf_pkg::req_t item;
    logic typed;
    mcaf_pkg::res_t want;
  } script_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  mcaf_pkg::req_t req;
  logic res_valid;
  logic res_ready;
  mcaf_pkg::res_t res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Predictor state: a private copy of the channel table and registers.
  logic [2:0] kind_q [NUM_CH];
  logic [1:0] stat_q [NUM_CH];
  logic [7:0] cnt_q [NUM_CH];
  logic [7:0] lvl_q;
  logic [7:0] fast_cfg;
  logic [7:0] slow_cfg;

  mcaf_pkg::res_t pending_levels [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  // Directed script: reset state, every kind, the extremes of each field.
  script_row_t directed_rows [0:22] = '{
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b1, '{8'h00, 8'h00}},
    '{'{mcaf_pkg::OP_STORE, 3'd0, mcaf_pkg::K_ACTIVATE, 8'd0}, 1'b1, '{8'h00, 8'h01}},
    '{'{mcaf_pkg::OP_TICK, 3'd7, 3'd7, 8'd255}, 1'b1, '{8'h01, 8'h00}},
    '{'{mcaf_pkg::OP_STORE, 3'd1, mcaf_pkg::K_DEACTIVATE, 8'd255}, 1'b1, '{8'h01, 8'h02}},
    '{'{mcaf_pkg::OP_STORE, 3'd0, mcaf_pkg::K_DEACTIVATE, 8'd0}, 1'b1, '{8'h01, 8'h03}},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b1, '{8'h00, 8'h00}},
    '{'{mcaf_pkg::OP_STORE, 3'd2, mcaf_pkg::K_FAST_TIMED, 8'd255}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd3, mcaf_pkg::K_FAST_STEADY, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd4, mcaf_pkg::K_SLOW_TIMED, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd5, mcaf_pkg::K_SLOW_STEADY, 8'd255}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd6, 3'd6, 8'hAA}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd7, 3'd7, 8'h55}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd1, mcaf_pkg::K_ACTIVATE, 8'd2}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd2, mcaf_pkg::K_FAST_TIMED, 8'd1}, 1'b0, '0},
    '{'{mcaf_pkg::OP_STORE, 3'd4, mcaf_pkg::K_SLOW_TIMED, 8'd6}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0},
    '{'{mcaf_pkg::OP_TICK, 3'd0, 3'd0, 8'd0}, 1'b0, '0}
  };

  multi_channel_actuator_flasher u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance one channel by one tick.
  function automatic void tick_channel(input int c);
    logic [7:0] cnt;
    logic [7:0] fp;
    logic [7:0] sp;
    cnt = cnt_q[c];
    fp = (fast_cfg == 8'd0) ? 8'd1 : fast_cfg;
    sp = (slow_cfg == 8'd0) ? 8'd1 : slow_cfg;
    case (kind_q[c])
      mcaf_pkg::K_FAST_TIMED: begin
        if (cnt == 8'd0) begin
          stat_q[c] = mcaf_pkg::ST_FINISHED;
          lvl_q[c] = 1'b0;
        end else begin
          if (cnt % fp == 8'd0) lvl_q[c] = ~lvl_q[c];
          cnt_q[c] = cnt - 8'd1;
        end
      end
      mcaf_pkg::K_SLOW_TIMED: begin
        if (cnt == 8'd0) begin
          stat_q[c] = mcaf_pkg::ST_FINISHED;
          lvl_q[c] = 1'b0;
        end else begin
          cnt = cnt - 8'd1;
          cnt_q[c] = cnt;
          if (cnt % sp == 8'd0) lvl_q[c] = ~lvl_q[c];
        end
      end
      mcaf_pkg::K_FAST_STEADY, mcaf_pkg::K_SLOW_STEADY: begin
        // Countdown reloads from the period when it expires, then always counts down.
        if (cnt == 8'd0) begin
          lvl_q[c] = ~lvl_q[c];
          cnt = (kind_q[c] == mcaf_pkg::K_FAST_STEADY) ? fp : sp;
        end
        cnt_q[c] = cnt - 8'd1;
      end
      mcaf_pkg::K_ACTIVATE: begin
        if (stat_q[c] == mcaf_pkg::ST_UNTREATED) begin
          lvl_q[c] = 1'b1;
          stat_q[c] = (cnt == 8'd0) ? mcaf_pkg::ST_FINISHED : mcaf_pkg::ST_UNDER;
        end else begin
          cnt = cnt - 8'd1;
          cnt_q[c] = cnt;
          if (cnt == 8'd0) begin
            lvl_q[c] = 1'b0;
            stat_q[c] = mcaf_pkg::ST_FINISHED;
          end
        end
      end
      mcaf_pkg::K_DEACTIVATE: begin
        lvl_q[c] = 1'b0;
        stat_q[c] = mcaf_pkg::ST_FINISHED;
      end
      default: begin
        stat_q[c] = mcaf_pkg::ST_FINISHED;
      end
    endcase
  endfunction

  // Apply one request to the predictor and return the levels and busy map after it.
  function automatic mcaf_pkg::res_t next_levels(input mcaf_pkg::req_t item);
    mcaf_pkg::res_t out;
    if (item.operation == mcaf_pkg::OP_STORE) begin
      kind_q[item.channel] = item.request_kind;
      cnt_q[item.channel] = item.duration;
      stat_q[item.channel] = mcaf_pkg::ST_UNTREATED;
    end else begin
      for (int c = 0; c < NUM_CH; c++)
        if (stat_q[c] != mcaf_pkg::ST_FINISHED) tick_channel(c);
    end
    out.levels = lvl_q;
    for (int c = 0; c < NUM_CH; c++)
      out.busy_res[c] = (stat_q[c] != mcaf_pkg::ST_FINISHED);
    return out;
  endfunction

  // Mostly ticks with short durations so that channels run through their whole life.
  function automatic mcaf_pkg::req_t random_request();
    mcaf_pkg::req_t r;
    r.operation = ($urandom_range(0, 99) < 60) ? mcaf_pkg::OP_TICK : mcaf_pkg::OP_STORE;
    r.channel = 3'($urandom_range(0, NUM_CH - 1));
    if ($urandom_range(0, 9) == 0)
      r.request_kind = 3'($urandom_range(6, 7));
    else
      r.request_kind = 3'($urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0)
      r.duration = 8'($urandom_range(0, 255));
    else
      r.duration = 8'($urandom_range(0, 12));
    return r;
  endfunction

  // Send one request in bursts with random gaps; valid stays up across a burst.
  task automatic send_request(input mcaf_pkg::req_t item, input logic typed,
                              input mcaf_pkg::res_t want);
    int gap;
    mcaf_pkg::res_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req_valid = 1'b1;
    req = item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = next_levels(item);
    pending_levels.push_back(typed ? want : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic wait_drained();
    req_valid = 1'b0;
    burst_left = 0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One write on the register port: setup cycle, then access cycle.
  task automatic write_register(input logic index, input logic [7:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = {24'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      mcaf_pkg::REG_FAST_PERIOD: fast_cfg = value;
      mcaf_pkg::REG_SLOW_PERIOD: slow_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Result receiver: stalls follow modes of random length.
  initial begin : res_stall
    int mode;
    int left;
    res_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: res_ready = 1'b1;
        1: res_ready = 1'($urandom_range(0, 1));
        default: res_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin : check_results
    mcaf_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result: levels %h busy_res %h", res.levels, res.busy_res);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        if (res.levels !== want.levels) begin
          $error("levels: expected %h, got %h", want.levels, res.levels);
          mismatch_count++;
        end
        if (res.busy_res !== want.busy_res) begin
          $error("busy_res: expected %h, got %h", want.busy_res, res.busy_res);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main sequence: reset, directed script, then random phases under several periods.
  initial begin : main_seq
    logic [7:0] fast_set [0:3];
    logic [7:0] slow_set [0:3];
    logic [7:0] fv;
    logic [7:0] sv;
    fast_set = '{8'd1, 8'd255, 8'd0, 8'd3};
    slow_set = '{8'd1, 8'd255, 8'd0, 8'd7};
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      kind_q[c] = mcaf_pkg::K_ACTIVATE;
      stat_q[c] = mcaf_pkg::ST_FINISHED;
      cnt_q[c] = 8'd0;
    end
    lvl_q = 8'd0;
    fast_cfg = mcaf_pkg::FAST_PERIOD_RST;
    slow_cfg = mcaf_pkg::SLOW_PERIOD_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset periods.
    foreach (directed_rows[i])
      send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own pair of periods.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 4) begin
        fv = fast_set[p];
        sv = slow_set[p];
      end else begin
        fv = 8'($urandom_range(1, 12));
        sv = 8'($urandom_range(1, 12));
      end
      write_register(mcaf_pkg::REG_FAST_PERIOD, fv);
      write_register(mcaf_pkg::REG_SLOW_PERIOD, sv);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_request(random_request(), 1'b0, '0);
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
